// ===== hdl/pksb_pkg.sv =====
// Package for the pressed key set buffer: sizes, request codes and word types.
package pksb_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int KEY_W      = 8;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int STEP_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    // Common width for position compares; holds every count and index.
    localparam int CMP_W      = 8;

    // Request kinds.
    localparam logic [1:0] KIND_PRESS   = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_CLEAR   = 2'd2;
    localparam logic [1:0] KIND_READ    = 2'd3;

    typedef struct packed {
        logic [1:0]       kind;
        logic [KEY_W-1:0] key_code;
        logic [3:0]       read_index;
    } pksb_in_t;

    typedef struct packed {
        logic [4:0]       key_count;
        logic [KEY_W-1:0] read_value;
        logic             read_valid;
        logic             already_present;
        logic             dropped_full;
        logic             release_missing;
    } pksb_out_t;

    // Control broadcast from the sequencer to the ring of cells.
    typedef struct packed {
        logic             shift;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] tail;
    } ring_ctl_t;

    // What the sequencer sees of the cell at the head of the ring.
    typedef struct packed {
        logic [KEY_W-1:0] entry;
        logic             match;
    } head_t;

endpackage

// ===== hdl/pressed_key_set_buffer_unit.sv =====
// Top level of the pressed key set buffer: ring of entry cells and its sequencer.
//
//   Channel   Signals                          Word
//   in        in_valid, in_ready, in_data      pksb_in_t  (kind, key_code, read_index)
//   out       out_valid, out_ready, out_data   pksb_out_t (count, read value, flags)
//
// For each word the entry ring rotates once, one cell per cycle, while the
// sequencer searches, inserts, removes or reads at the head; the output
// register is then loaded with the result.
// Reset empties the list at once; no clearing pass is needed.
// A result waiting in the output register does not block the next word's
// walk; only the load of its own result waits for out_ready.
module pressed_key_set_buffer_unit
    import pksb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  pksb_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output pksb_out_t out_data
);

    ring_ctl_t        ring_ctl;
    head_t            head;
    logic [KEY_W-1:0] second;
    logic [KEY_W-1:0] entry [LIST_DEPTH];
    logic             match [LIST_DEPTH];

    // Ring of cells; each takes its upper neighbor, the last takes the tail feed.
    for (genvar i = 0; i < LIST_DEPTH; i++)
    begin : g_cell
        logic [KEY_W-1:0] upstream;
        if (i == LIST_DEPTH - 1)
        begin : g_last
            assign upstream = ring_ctl.tail;
        end
        else
        begin : g_mid
            assign upstream = entry[i+1];
        end

        pksb_cell u_cell (
            .clk      (clk),
            .ctl      (ring_ctl),
            .upstream (upstream),
            .entry    (entry[i]),
            .match    (match[i])
        );
    end

    // The head's neighbor; with a single cell the ring wraps onto itself.
    if (LIST_DEPTH > 1)
    begin : g_second
        assign second = entry[1];
    end
    else
    begin : g_second_wrap
        assign second = entry[0];
    end

    assign head.entry = entry[0];
    assign head.match = match[0];

    pksb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .ring_ctl  (ring_ctl),
        .head      (head),
        .second    (second)
    );

endmodule

// ===== hdl/pksb_cell.sv =====
// One ring cell: holds a list entry, shifts toward the head and compares with the key.
module pksb_cell
    import pksb_pkg::*;
(
    input  logic             clk,
    input  ring_ctl_t        ctl,
    input  logic [KEY_W-1:0] upstream,
    output logic [KEY_W-1:0] entry,
    output logic             match
);

    logic [KEY_W-1:0] entry_reg;
    logic [KEY_W-1:0] entry_next;

    // Take the neighbor's entry on every step of a walk.
    always_comb
    begin
        entry_next = ctl.shift ? upstream : entry_reg;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign match = (entry_reg == ctl.key);

endmodule

// ===== hdl/pksb_ctrl.sv =====
// Sequencer: walks the ring once per request, edits the list in flight, builds the result.
module pksb_ctrl
    import pksb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  pksb_in_t         in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output pksb_out_t        out_data,
    output ring_ctl_t        ring_ctl,
    input  head_t            head,
    input  logic [KEY_W-1:0] second
);

    typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_FINISH} state_t;

    state_t           state_reg,     state_next;
    logic [STEP_W-1:0] step_reg,     step_next;
    logic [CNT_W-1:0] count_reg,     count_next;
    pksb_in_t         item_reg,      item_next;
    logic             found_reg,     found_next;
    logic [KEY_W-1:0] rd_val_reg,    rd_val_next;
    logic             rd_ok_reg,     rd_ok_next;
    logic             present_reg,   present_next;
    logic             dropped_reg,   dropped_next;
    logic             missing_reg,   missing_next;
    logic             out_valid_reg, out_valid_next;
    pksb_out_t        out_reg,       out_next;

    logic             pos_ok;
    logic             at_count;
    logic             at_index;
    logic             last_step;
    logic             is_full;
    logic             searching;
    logic             hit;
    logic             found_now;
    logic [KEY_W-1:0] tail_data;

    // Position of the entry now at the head, against the list length and read index.
    assign pos_ok    = CMP_W'(step_reg) < CMP_W'(count_reg);
    assign at_count  = CMP_W'(step_reg) == CMP_W'(count_reg);
    assign at_index  = CMP_W'(step_reg) == CMP_W'(item_reg.read_index);
    assign last_step = step_reg == STEP_W'(LIST_DEPTH - 1);
    assign is_full   = count_reg == CNT_W'(LIST_DEPTH);
    assign searching = (item_reg.kind == KIND_PRESS) || (item_reg.kind == KIND_RELEASE);
    assign hit       = head.match && pos_ok && !found_reg && searching;
    assign found_now = found_reg || hit;

    // Value fed into the tail of the ring. A release feeds the head's
    // neighbor from the match onward, which closes the gap. A press puts
    // the new code in the first free place when no match was seen.
    always_comb
    begin
        tail_data = head.entry;
        case (item_reg.kind)
            KIND_PRESS:
            begin
                if (at_count && !found_reg)
                begin
                    tail_data = item_reg.key_code;
                end
            end
            KIND_RELEASE:
            begin
                if (found_now)
                begin
                    tail_data = second;
                end
            end
            default:
            begin
                tail_data = head.entry;
            end
        endcase
    end

    assign ring_ctl.shift = (state_reg == ST_WALK);
    assign ring_ctl.key   = item_reg.key_code;
    assign ring_ctl.tail  = tail_data;

    // Next-state logic for the sequencer and the output register.
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        count_next     = count_reg;
        item_next      = item_reg;
        found_next     = found_reg;
        rd_val_next    = rd_val_reg;
        rd_ok_next     = rd_ok_reg;
        present_next   = present_reg;
        dropped_next   = dropped_reg;
        missing_next   = missing_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    step_next  = '0;
                    found_next = 1'b0;
                    rd_ok_next = 1'b0;
                    rd_val_next = '0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                found_next = found_now;
                if ((item_reg.kind == KIND_READ) && at_index && pos_ok)
                begin
                    rd_val_next = head.entry;
                    rd_ok_next  = 1'b1;
                end
                step_next = step_reg + STEP_W'(1);
                if (last_step)
                begin
                    step_next    = '0;
                    present_next = 1'b0;
                    dropped_next = 1'b0;
                    missing_next = 1'b0;
                    case (item_reg.kind)
                        KIND_PRESS:
                        begin
                            present_next = found_now;
                            dropped_next = !found_now && is_full;
                            if (!found_now && !is_full)
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        KIND_RELEASE:
                        begin
                            missing_next = !found_now;
                            if (found_now)
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        KIND_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // Wait until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    out_next.key_count       = 5'(count_reg);
                    out_next.read_value      = rd_val_reg;
                    out_next.read_valid      = rd_ok_reg;
                    out_next.already_present = present_reg;
                    out_next.dropped_full    = dropped_reg;
                    out_next.release_missing = missing_reg;
                    out_valid_next           = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, working registers and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            count_reg     <= '0;
            item_reg      <= '0;
            found_reg     <= 1'b0;
            rd_val_reg    <= '0;
            rd_ok_reg     <= 1'b0;
            present_reg   <= 1'b0;
            dropped_reg   <= 1'b0;
            missing_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            item_reg      <= item_next;
            found_reg     <= found_next;
            rd_val_reg    <= rd_val_next;
            rd_ok_reg     <= rd_ok_next;
            present_reg   <= present_next;
            dropped_reg   <= dropped_next;
            missing_reg   <= missing_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== hdl/pksb_checker.sv =====
// Port checker for the pressed key set buffer, bound to the top level.
module pksb_checker
    import pksb_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input pksb_in_t  in_data,
    input logic      out_valid,
    input logic      out_ready,
    input pksb_out_t out_data
);

    // A stalled result word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // At most one of the status flags is raised in any result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $countones({out_data.read_valid, out_data.already_present,
                                  out_data.dropped_full, out_data.release_missing}) <= 1)
        else $error("more than one status flag in a result");

    // A failed or absent read returns zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.read_valid |-> out_data.read_value == '0)
        else $error("read value not zero without a valid read");

    // Each accepted word starts a walk, so the input is busy next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted on consecutive cycles");

endmodule

bind pressed_key_set_buffer_unit pksb_checker u_pksb_checker (.*);
